[design/seg_ell_pkg.sv]
// Shared types, widths, stage map and saturating helpers for the segment /
// ellipse intersection core. No dependencies.
package seg_ell_pkg;

   localparam int FRAC_BITS = 16;
   localparam int CRD_W     = 32;
   localparam int AXIS_W    = 31;
   localparam int WIDE_W    = 64;
   localparam int NUM_W     = WIDE_W + FRAC_BITS;
   localparam int ROOT_W    = NUM_W / 2;

   localparam logic signed [WIDE_W-1:0] SAT_MAX = {1'b0, {(WIDE_W-1){1'b1}}};
   localparam logic [AXIS_W-1:0] AXIS_RESET = AXIS_W'(1) << FRAC_BITS;

   localparam int MUL_LAT  = 3;
   localparam int DIV_LAT  = NUM_W + 2;
   localparam int SQRT_LAT = ROOT_W + 1;

   // stage map: a value is folded into the stage at the given index
   localparam int ST_VSQ   = 2;
   localparam int ST_VMUL  = ST_VSQ + SQRT_LAT + 1;
   localparam int ST_VDIV  = ST_VMUL + DIV_LAT + 1;
   localparam int ST_VCAND = ST_VDIV + 1;
   localparam int ST_ALPHA = DIV_LAT + 1;
   localparam int ST_BETA  = ST_ALPHA + MUL_LAT + 1;
   localparam int ST_BB    = ST_BETA + MUL_LAT + 1;
   localparam int ST_DISC  = ST_BB + MUL_LAT + 1;
   localparam int ST_Q     = ST_DISC + SQRT_LAT + 1;
   localparam int ST_U     = ST_Q + DIV_LAT + 1;
   localparam int ST_GX    = ST_U + 1;
   localparam int ST_GY    = ST_U + MUL_LAT + 1;
   localparam int ST_BOX   = ST_GY + 1;
   localparam int ST_OUT   = ST_BOX + 1;
   localparam int NST      = ST_OUT + 1;

   typedef enum logic [1:0] {
      REG_CENTER_X,
      REG_CENTER_Y,
      REG_AXIS_X,
      REG_AXIS_Y
   } csr_index_type;

   typedef logic signed [WIDE_W-1:0] wide_type;

   typedef struct packed {
      logic signed [CRD_W-1:0] sx;
      logic signed [CRD_W-1:0] sy;
      logic signed [CRD_W-1:0] ex;
      logic signed [CRD_W-1:0] ey;
      logic                    vert;
      wide_type                dx;
      wide_type                dy;
      wide_type                dxc;
      wide_type                dyc;
      wide_type                dv;
      logic                    vin;
      logic [WIDE_W-1:0]       a2;
      logic [WIDE_W-1:0]       d2;
      logic [WIDE_W-1:0]       rad;
      wide_type                vmul;
      wide_type                s;
      wide_type                vy0;
      wide_type                vy1;
      wide_type                alpha;
      wide_type                ratio;
      wide_type                r;
      wide_type                b2;
      wide_type                big_a;
      wide_type                beta;
      wide_type                bb;
      wide_type                hh;
      wide_type                t2;
      wide_type                cc;
      wide_type                off;
      wide_type                dd;
      wide_type                sd;
      logic                    dneg;
      wide_type                q;
      wide_type                u0;
      wide_type                u1;
      wide_type                gx0;
      wide_type                gx1;
      wide_type                gy0;
      wide_type                gy1;
      wide_type                c0x;
      wide_type                c0y;
      wide_type                c1x;
      wide_type                c1y;
      logic                    in0;
      logic                    in1;
      logic [1:0]              cnt;
      logic signed [CRD_W-1:0] fx;
      logic signed [CRD_W-1:0] fy;
      logic signed [CRD_W-1:0] scx;
      logic signed [CRD_W-1:0] scy;
   } item_type;

   function automatic logic [WIDE_W-1:0] mag64(input wide_type v);
      return v[WIDE_W-1] ? WIDE_W'(-v) : WIDE_W'(v);
   endfunction

   function automatic wide_type sat_clip(input logic signed [WIDE_W:0] s);
      logic signed [WIDE_W:0] hi;
      hi = (WIDE_W+1)'(SAT_MAX);
      if (s > hi) return SAT_MAX;
      if (s < -hi) return -SAT_MAX;
      return s[WIDE_W-1:0];
   endfunction

   function automatic wide_type sat_add(input wide_type a, input wide_type b);
      logic signed [WIDE_W:0] s;
      s = (WIDE_W+1)'(a) + (WIDE_W+1)'(b);
      return sat_clip(s);
   endfunction

   function automatic wide_type sat_sub(input wide_type a, input wide_type b);
      logic signed [WIDE_W:0] s;
      s = (WIDE_W+1)'(a) - (WIDE_W+1)'(b);
      return sat_clip(s);
   endfunction

endpackage

[design/seg_ell_mul.sv]
// Pipelined fixed point multiplier, rounded half away from zero, saturated.
// Depends on seg_ell_pkg.
module seg_ell_mul import seg_ell_pkg::*; (
   input  logic     clock,
   input  logic     en,
   input  wide_type op_a,
   input  wide_type op_b,
   output wide_type result
);

   localparam logic [2*WIDE_W-1:0] HALF = (2*WIDE_W)'(1) << (FRAC_BITS - 1);

   logic [WIDE_W-1:0]   am_ff, bm_ff;
   logic                neg1_ff, neg2_ff;
   logic [WIDE_W-1:0]   pll_ff, plh_ff, phl_ff, phh_ff;
   logic [2*WIDE_W-1:0] sum_w;
   logic [WIDE_W-1:0]   mag_w;
   wide_type            res_ff;

   always_comb begin
      sum_w = (2*WIDE_W)'(pll_ff) + ((2*WIDE_W)'(plh_ff) << (WIDE_W/2))
            + ((2*WIDE_W)'(phl_ff) << (WIDE_W/2)) + ((2*WIDE_W)'(phh_ff) << WIDE_W) + HALF;
      if (|sum_w[2*WIDE_W-1:WIDE_W+FRAC_BITS-1]) mag_w = WIDE_W'(SAT_MAX);
      else mag_w = sum_w[WIDE_W+FRAC_BITS-1:FRAC_BITS];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         am_ff   <= mag64(op_a);
         bm_ff   <= mag64(op_b);
         neg1_ff <= op_a[WIDE_W-1] ^ op_b[WIDE_W-1];
         pll_ff  <= am_ff[WIDE_W/2-1:0] * bm_ff[WIDE_W/2-1:0];
         plh_ff  <= am_ff[WIDE_W/2-1:0] * bm_ff[WIDE_W-1:WIDE_W/2];
         phl_ff  <= am_ff[WIDE_W-1:WIDE_W/2] * bm_ff[WIDE_W/2-1:0];
         phh_ff  <= am_ff[WIDE_W-1:WIDE_W/2] * bm_ff[WIDE_W-1:WIDE_W/2];
         neg2_ff <= neg1_ff;
         res_ff  <= neg2_ff ? -wide_type'(mag_w) : wide_type'(mag_w);
      end
   end

   assign result = res_ff;

endmodule

[design/seg_ell_div.sv]
// Pipelined restoring divider, one quotient bit per stage, returning
// (num << FRAC_BITS) / den truncated and saturated. Depends on seg_ell_pkg.
module seg_ell_div import seg_ell_pkg::*; (
   input  logic     clock,
   input  logic     en,
   input  wide_type num,
   input  wide_type den,
   output wide_type quot
);

   logic [WIDE_W-1:0] n_ff   [NUM_W+1];
   logic [WIDE_W-1:0] d_ff   [NUM_W+1];
   logic [WIDE_W-1:0] rem_ff [NUM_W+1];
   logic [NUM_W-1:0]  quo_ff [NUM_W+1];
   logic              neg_ff [NUM_W+1];
   logic              xn_ff  [NUM_W+1];
   wide_type          quot_ff;
   logic [WIDE_W-1:0] qmag_w;

   always_ff @(posedge clock) begin
      if (en) begin
         n_ff[0]   <= mag64(num);
         d_ff[0]   <= mag64(den);
         rem_ff[0] <= '0;
         quo_ff[0] <= '0;
         neg_ff[0] <= num[WIDE_W-1] ^ den[WIDE_W-1];
         xn_ff[0]  <= num[WIDE_W-1];
      end
   end

   for (genvar k = 1; k <= NUM_W; k++) begin : g_step
      localparam int BIT_I = NUM_W - k;
      logic          nb;
      logic [WIDE_W:0] trial;
      logic          take;

      if (BIT_I >= FRAC_BITS) begin : g_bit
         assign nb = n_ff[k-1][BIT_I-FRAC_BITS];
      end else begin : g_zero
         assign nb = 1'b0;
      end

      assign trial = {rem_ff[k-1], nb};
      assign take  = trial >= {1'b0, d_ff[k-1]};

      always_ff @(posedge clock) begin
         if (en) begin
            n_ff[k]   <= n_ff[k-1];
            d_ff[k]   <= d_ff[k-1];
            rem_ff[k] <= take ? WIDE_W'(trial - {1'b0, d_ff[k-1]}) : trial[WIDE_W-1:0];
            quo_ff[k] <= {quo_ff[k-1][NUM_W-2:0], take};
            neg_ff[k] <= neg_ff[k-1];
            xn_ff[k]  <= xn_ff[k-1];
         end
      end
   end

   always_comb begin
      if (|quo_ff[NUM_W][NUM_W-1:WIDE_W-1]) qmag_w = WIDE_W'(SAT_MAX);
      else qmag_w = quo_ff[NUM_W][WIDE_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         if (d_ff[NUM_W] == '0) begin
            if (n_ff[NUM_W] == '0) quot_ff <= '0;
            else quot_ff <= xn_ff[NUM_W] ? -SAT_MAX : SAT_MAX;
         end else begin
            quot_ff <= neg_ff[NUM_W] ? -wide_type'(qmag_w) : wide_type'(qmag_w);
         end
      end
   end

   assign quot = quot_ff;

endmodule

[design/seg_ell_sqrt.sv]
// Pipelined integer square root, two radicand bits per stage, floor result.
// Depends on seg_ell_pkg.
module seg_ell_sqrt import seg_ell_pkg::*; (
   input  logic              clock,
   input  logic              en,
   input  logic [NUM_W-1:0]  rad,
   output logic [ROOT_W-1:0] root
);

   logic [NUM_W-1:0]  v_ff    [ROOT_W+1];
   logic [ROOT_W+1:0] rem_ff  [ROOT_W+1];
   logic [ROOT_W-1:0] root_ff [ROOT_W+1];

   always_ff @(posedge clock) begin
      if (en) begin
         v_ff[0]    <= rad;
         rem_ff[0]  <= '0;
         root_ff[0] <= '0;
      end
   end

   for (genvar k = 1; k <= ROOT_W; k++) begin : g_step
      localparam int PAIR = ROOT_W - k;
      logic [ROOT_W+1:0] remx, trial;
      logic              take;

      assign remx  = {rem_ff[k-1][ROOT_W-1:0], v_ff[k-1][2*PAIR+1:2*PAIR]};
      assign trial = {root_ff[k-1], 2'b01};
      assign take  = remx >= trial;

      always_ff @(posedge clock) begin
         if (en) begin
            v_ff[k]    <= v_ff[k-1];
            rem_ff[k]  <= take ? remx - trial : remx;
            root_ff[k] <= {root_ff[k-1][ROOT_W-2:0], take};
         end
      end
   end

   assign root = root_ff[ROOT_W];

endmodule

[design/segment_ellipse_intersect_core.sv]
// Segment / axis-aligned ellipse intersection core, top level.
// Depends on seg_ell_pkg, seg_ell_mul, seg_ell_div and seg_ell_sqrt.
// One segment word enters per clock unless the pipeline holds; the depth is
// set by the chain of divider, multiplier and square root pipelines, and the
// divider's one quotient bit per stage dominates it. The whole pipeline
// holds while a result waits on rsp_ready.
// Write csr registers only while no segment is in flight.
module segment_ellipse_intersect_core import seg_ell_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [1:0]              csr_index,
   input  logic [CRD_W-1:0]        csr_data,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic signed [CRD_W-1:0] req_start_x,
   input  logic signed [CRD_W-1:0] req_start_y,
   input  logic signed [CRD_W-1:0] req_end_x,
   input  logic signed [CRD_W-1:0] req_end_y,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [1:0]              rsp_hit_count,
   output logic signed [CRD_W-1:0] rsp_first_x,
   output logic signed [CRD_W-1:0] rsp_first_y,
   output logic signed [CRD_W-1:0] rsp_second_x,
   output logic signed [CRD_W-1:0] rsp_second_y
);

   logic signed [CRD_W-1:0] cx_ff, cy_ff;
   logic [AXIS_W-1:0]       ax_ff, ay_ff;
   logic                    adv;
   logic                    vld_ff  [NST];
   item_type                item_ff [NST];
   item_type                item_in [NST];

   wide_type            alpha_q, ratio_q, vq, u0_q, u1_q;
   wide_type            m_t1, m_r, m_b2, m_aa, m_bb, m_h, m_t2, m_t3, m_g0, m_g1;
   logic [ROOT_W-1:0]   vw_root, sd_root;
   logic [2*AXIS_W-1:0] va2_w, vmul_w;
   logic [WIDE_W-1:0]   vd2_w;
   logic [CRD_W-1:0]    dmag_w;
   wide_type            wcx, wcy;

   assign csr_ready = 1'b1;
   assign adv       = !vld_ff[NST-1] || rsp_ready;
   assign req_ready = adv;
   assign wcx       = wide_type'(cx_ff);
   assign wcy       = wide_type'(cy_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         cx_ff <= '0;
         cy_ff <= '0;
         ax_ff <= AXIS_RESET;
         ay_ff <= AXIS_RESET;
      end else if (csr_valid) begin
         case (csr_index_type'(csr_index))
            REG_CENTER_X: cx_ff <= csr_data;
            REG_CENTER_Y: cy_ff <= csr_data;
            REG_AXIS_X:   ax_ff <= csr_data[AXIS_W-1:0];
            REG_AXIS_Y:   ay_ff <= csr_data[AXIS_W-1:0];
            default:      cx_ff <= cx_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < NST; k++) vld_ff[k] <= 1'b0;
      end else if (adv) begin
         vld_ff[0] <= req_valid;
         for (int k = 1; k < NST; k++) vld_ff[k] <= vld_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k < NST; k++) item_ff[k] <= item_in[k];
      end
   end

   assign dmag_w = CRD_W'(mag64(item_ff[0].dv));
   assign va2_w  = ax_ff * ax_ff;
   assign vd2_w  = dmag_w * dmag_w;
   assign vmul_w = ay_ff * vw_root[AXIS_W-1:0];

   // vertical branch
   seg_ell_sqrt u_vsqrt (.clock, .en(adv),
      .rad(NUM_W'(item_ff[ST_VSQ].rad)), .root(vw_root));
   seg_ell_div u_vdiv (.clock, .en(adv), .num(item_ff[ST_VMUL].vmul),
      .den(wide_type'(ax_ff)), .quot(vq));

   // slope and axis ratio
   seg_ell_div u_alpha (.clock, .en(adv), .num(item_ff[0].dy), .den(item_ff[0].dx),
      .quot(alpha_q));
   seg_ell_div u_ratio (.clock, .en(adv), .num(wide_type'(ay_ff)),
      .den(wide_type'(ax_ff)), .quot(ratio_q));

   seg_ell_mul u_t1 (.clock, .en(adv), .op_a(item_ff[ST_ALPHA].alpha),
      .op_b(item_ff[ST_ALPHA].dxc), .result(m_t1));
   seg_ell_mul u_r (.clock, .en(adv), .op_a(item_ff[ST_ALPHA].ratio),
      .op_b(item_ff[ST_ALPHA].ratio), .result(m_r));
   seg_ell_mul u_b2 (.clock, .en(adv), .op_a(wide_type'(ay_ff)),
      .op_b(wide_type'(ay_ff)), .result(m_b2));
   seg_ell_mul u_aa (.clock, .en(adv), .op_a(item_ff[ST_ALPHA].alpha),
      .op_b(item_ff[ST_ALPHA].alpha), .result(m_aa));

   seg_ell_mul u_bb (.clock, .en(adv), .op_a(item_ff[ST_BETA].beta),
      .op_b(item_ff[ST_BETA].beta), .result(m_bb));
   seg_ell_mul u_h (.clock, .en(adv), .op_a(item_ff[ST_BETA].alpha),
      .op_b(item_ff[ST_BETA].beta), .result(m_h));
   seg_ell_mul u_t2 (.clock, .en(adv), .op_a(item_ff[ST_BETA].b2),
      .op_b(item_ff[ST_BETA].big_a), .result(m_t2));

   seg_ell_mul u_t3 (.clock, .en(adv), .op_a(item_ff[ST_BB].r),
      .op_b(item_ff[ST_BB].bb), .result(m_t3));

   seg_ell_sqrt u_dsqrt (.clock, .en(adv),
      .rad(item_ff[ST_DISC].dd[WIDE_W-1] ? '0 : NUM_W'(item_ff[ST_DISC].dd) << FRAC_BITS),
      .root(sd_root));

   seg_ell_div u_u0 (.clock, .en(adv), .num(item_ff[ST_Q].cc), .den(item_ff[ST_Q].q),
      .quot(u0_q));
   seg_ell_div u_u1 (.clock, .en(adv), .num(item_ff[ST_Q].q), .den(item_ff[ST_Q].big_a),
      .quot(u1_q));

   seg_ell_mul u_g0 (.clock, .en(adv), .op_a(item_ff[ST_U].alpha),
      .op_b(item_ff[ST_U].u0), .result(m_g0));
   seg_ell_mul u_g1 (.clock, .en(adv), .op_a(item_ff[ST_U].alpha),
      .op_b(item_ff[ST_U].u1), .result(m_g1));

   always_comb begin
      logic [1:0] n;
      logic       swap;
      item_type   b;

      item_in[0]      = '0;
      item_in[0].sx   = req_start_x;
      item_in[0].sy   = req_start_y;
      item_in[0].ex   = req_end_x;
      item_in[0].ey   = req_end_y;
      item_in[0].vert = req_end_x == req_start_x;
      item_in[0].dx   = wide_type'(req_end_x) - wide_type'(req_start_x);
      item_in[0].dy   = wide_type'(req_end_y) - wide_type'(req_start_y);
      item_in[0].dxc  = wide_type'(req_start_x) - wcx;
      item_in[0].dyc  = wide_type'(req_start_y) - wcy;
      item_in[0].dv   = wide_type'(req_end_x) - wcx;

      for (int k = 1; k < NST; k++) item_in[k] = item_ff[k-1];

      item_in[1].vin = mag64(item_ff[0].dv) <= WIDE_W'(ax_ff);
      item_in[1].a2  = WIDE_W'(va2_w);
      item_in[1].d2  = vd2_w;

      item_in[ST_VSQ].rad = item_ff[ST_VSQ-1].a2 - item_ff[ST_VSQ-1].d2;

      item_in[ST_VMUL].vmul = wide_type'(vmul_w);

      item_in[ST_VDIV].s = (ax_ff == '0) ? '0 : vq >>> FRAC_BITS;

      item_in[ST_VCAND].vy0 = wcy - item_ff[ST_VCAND-1].s;
      item_in[ST_VCAND].vy1 = wcy + item_ff[ST_VCAND-1].s;

      item_in[ST_ALPHA].alpha = alpha_q;
      item_in[ST_ALPHA].ratio = ratio_q;

      item_in[ST_BETA].beta  = sat_sub(item_ff[ST_BETA-1].dyc, m_t1);
      item_in[ST_BETA].big_a = sat_add(m_r, m_aa);
      item_in[ST_BETA].r     = m_r;
      item_in[ST_BETA].b2    = m_b2;

      item_in[ST_BB].bb  = m_bb;
      item_in[ST_BB].hh  = m_h;
      item_in[ST_BB].t2  = m_t2;
      item_in[ST_BB].cc  = sat_sub(m_bb, item_ff[ST_BB-1].b2);
      item_in[ST_BB].off = sat_add(item_ff[ST_BB-1].beta, wcy);

      item_in[ST_DISC].dd = sat_sub(item_ff[ST_DISC-1].t2, m_t3);

      item_in[ST_Q].sd   = wide_type'(sd_root);
      item_in[ST_Q].dneg = item_ff[ST_Q-1].dd[WIDE_W-1];
      if (item_ff[ST_Q-1].hh[WIDE_W-1])
         item_in[ST_Q].q = sat_sub(wide_type'(sd_root), item_ff[ST_Q-1].hh);
      else
         item_in[ST_Q].q = -sat_add(item_ff[ST_Q-1].hh, wide_type'(sd_root));

      item_in[ST_U].u0 = (item_ff[ST_U-1].q == '0) ? '0 : u0_q;
      item_in[ST_U].u1 = u1_q;

      item_in[ST_GX].gx0 = sat_add(item_ff[ST_GX-1].u0, wcx);
      item_in[ST_GX].gx1 = sat_add(item_ff[ST_GX-1].u1, wcx);

      item_in[ST_GY].gy0 = sat_add(m_g0, item_ff[ST_GY-1].off);
      item_in[ST_GY].gy1 = sat_add(m_g1, item_ff[ST_GY-1].off);

      b = item_ff[ST_BOX-1];
      if (b.vert) begin
         item_in[ST_BOX].c0x = wide_type'(b.ex);
         item_in[ST_BOX].c0y = b.vy0;
         item_in[ST_BOX].c1x = wide_type'(b.ex);
         item_in[ST_BOX].c1y = b.vy1;
         item_in[ST_BOX].in0 = b.vin;
         item_in[ST_BOX].in1 = b.vin && (b.s != '0);
      end else begin
         item_in[ST_BOX].c0x = b.gx0;
         item_in[ST_BOX].c0y = b.gy0;
         item_in[ST_BOX].c1x = b.gx1;
         item_in[ST_BOX].c1y = b.gy1;
         item_in[ST_BOX].in0 = !b.dneg;
         item_in[ST_BOX].in1 = !b.dneg && (b.sd != '0);
      end
      item_in[ST_BOX].in0 = item_in[ST_BOX].in0
         && item_in[ST_BOX].c0x <= wide_type'(b.ex) && item_in[ST_BOX].c0x >= wide_type'(b.sx)
         && item_in[ST_BOX].c0y <= wide_type'(b.ey) && item_in[ST_BOX].c0y >= wide_type'(b.sy);
      item_in[ST_BOX].in1 = item_in[ST_BOX].in1
         && item_in[ST_BOX].c1x <= wide_type'(b.ex) && item_in[ST_BOX].c1x >= wide_type'(b.sx)
         && item_in[ST_BOX].c1y <= wide_type'(b.ey) && item_in[ST_BOX].c1y >= wide_type'(b.sy);

      b    = item_ff[ST_OUT-1];
      n    = 2'(b.in0) + 2'(b.in1);
      swap = b.in0 && b.in1 && (b.c1x < b.c0x);
      item_in[ST_OUT].cnt = n;
      item_in[ST_OUT].fx  = '0;
      item_in[ST_OUT].fy  = '0;
      item_in[ST_OUT].scx = '0;
      item_in[ST_OUT].scy = '0;
      if (b.in0 && b.in1) begin
         item_in[ST_OUT].fx  = swap ? b.c1x[CRD_W-1:0] : b.c0x[CRD_W-1:0];
         item_in[ST_OUT].fy  = swap ? b.c1y[CRD_W-1:0] : b.c0y[CRD_W-1:0];
         item_in[ST_OUT].scx = swap ? b.c0x[CRD_W-1:0] : b.c1x[CRD_W-1:0];
         item_in[ST_OUT].scy = swap ? b.c0y[CRD_W-1:0] : b.c1y[CRD_W-1:0];
      end else if (b.in0) begin
         item_in[ST_OUT].fx = b.c0x[CRD_W-1:0];
         item_in[ST_OUT].fy = b.c0y[CRD_W-1:0];
      end else if (b.in1) begin
         item_in[ST_OUT].fx = b.c1x[CRD_W-1:0];
         item_in[ST_OUT].fy = b.c1y[CRD_W-1:0];
      end
   end

   assign rsp_valid     = vld_ff[NST-1];
   assign rsp_hit_count = item_ff[NST-1].cnt;
   assign rsp_first_x   = item_ff[NST-1].fx;
   assign rsp_first_y   = item_ff[NST-1].fy;
   assign rsp_second_x  = item_ff[NST-1].scx;
   assign rsp_second_y  = item_ff[NST-1].scy;

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_hit_count != 2'd3)
      else $error("hit count out of range");

   a_first_clear: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_hit_count == 2'd0 |-> rsp_first_x == '0 && rsp_first_y == '0)
      else $error("first point set without a hit");

   a_second_clear: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_hit_count != 2'd2 |-> rsp_second_x == '0 && rsp_second_y == '0)
      else $error("second point set without two hits");

   a_sorted: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_hit_count == 2'd2 |-> rsp_first_x <= rsp_second_x)
      else $error("points not ordered by x");

endmodule
